// ===== rtl/core/dfmw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfmw_pkg: shared types and constants for the maze walker
// Codes, direction table and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package dfmw_pkg;

   localparam int KIND_W  = 2;
   localparam int POS_W   = 6;
   localparam int MASK_W  = 8;
   localparam int CFG_W   = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_STEP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;

   localparam logic [2:0] DIR_LAST = 3'd7;

   // Search order N, NE, E, SE, S, SW, W, NW; offsets in two's complement.
   localparam logic [1:0] DIR_DX [8] = '{2'b00, 2'b01, 2'b01, 2'b01,
                                         2'b00, 2'b11, 2'b11, 2'b11};
   localparam logic [1:0] DIR_DY [8] = '{2'b11, 2'b11, 2'b00, 2'b01,
                                         2'b01, 2'b01, 2'b00, 2'b11};
   localparam logic [MASK_W-1:0] DIR_BIT [8] = '{8'h01, 8'h02, 8'h40, 8'h08,
                                                 8'h10, 8'h20, 8'h04, 8'h80};

   typedef enum logic [1:0] {
      ACT_ACK     = 2'd0,
      ACT_ADVANCE = 2'd1,
      ACT_BACK    = 2'd2,
      ACT_DONE    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_BOOT,
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_DIR,
      ST_CHECK,
      ST_POP_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       wall_wr;
      logic       wall_rd;
      logic       open_load;
      logic       open_zero;
      logic       set_action;
      action_type action;
      logic       restart;
      logic       clear_step;
      logic       dir_zero;
      logic       dir_inc;
      logic       vis_rd;
      logic       push;
      logic       pop;
      logic       pop_load;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic goal;
      logic dir_open;
      logic dir_last;
      logic visit_ok;
      logic clear_last;
   } status_type;

endpackage

// ===== rtl/core/dfmw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfmw_ctrl: maze walker sequencer
// Walks each step transaction through wall read, neighbor checks, push or pop,
// and hands every result to the output register.
// ----------------------------------------------------------------------------
module dfmw_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dfmw_pkg::KIND_W-1:0]       req_kind,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  dfmw_pkg::status_type              status,
   output dfmw_pkg::cmd_type                 cmd
);

   dfmw_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfmw_pkg::ST_BOOT: begin
            if (status.clear_last) state_in = dfmw_pkg::ST_IDLE;
         end
         dfmw_pkg::ST_CLEAR: begin
            if (status.clear_last) state_in = dfmw_pkg::ST_FINISH;
         end
         dfmw_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  dfmw_pkg::KIND_RESTART: state_in = dfmw_pkg::ST_CLEAR;
                  dfmw_pkg::KIND_STEP: begin
                     state_in = status.count_zero ? dfmw_pkg::ST_FINISH
                                                  : dfmw_pkg::ST_EVAL;
                  end
                  default: state_in = dfmw_pkg::ST_FINISH;
               endcase
            end
         end
         dfmw_pkg::ST_EVAL: begin
            state_in = status.goal ? dfmw_pkg::ST_FINISH : dfmw_pkg::ST_DIR;
         end
         dfmw_pkg::ST_DIR: begin
            priority if (status.dir_open) state_in = dfmw_pkg::ST_CHECK;
            else if (status.dir_last) begin
               state_in = status.count_one ? dfmw_pkg::ST_FINISH
                                           : dfmw_pkg::ST_POP_WAIT;
            end
         end
         dfmw_pkg::ST_CHECK: begin
            priority if (status.visit_ok) state_in = dfmw_pkg::ST_FINISH;
            else if (status.dir_last) begin
               state_in = status.count_one ? dfmw_pkg::ST_FINISH
                                           : dfmw_pkg::ST_POP_WAIT;
            end
            else state_in = dfmw_pkg::ST_DIR;
         end
         dfmw_pkg::ST_POP_WAIT: state_in = dfmw_pkg::ST_FINISH;
         dfmw_pkg::ST_FINISH: begin
            if (out_free) state_in = dfmw_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.action = dfmw_pkg::ACT_ACK;
      req_ready  = 1'b0;
      unique case (state_ff)
         dfmw_pkg::ST_BOOT,
         dfmw_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         dfmw_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.open_zero  = 1'b1;
               cmd.set_action = 1'b1;
               unique case (req_kind)
                  dfmw_pkg::KIND_LOAD:    cmd.wall_wr = 1'b1;
                  dfmw_pkg::KIND_RESTART: cmd.restart = 1'b1;
                  dfmw_pkg::KIND_STEP: begin
                     cmd.action  = dfmw_pkg::ACT_DONE;
                     cmd.wall_rd = !status.count_zero;
                  end
                  default: cmd.action = dfmw_pkg::ACT_ACK;
               endcase
            end
         end
         dfmw_pkg::ST_EVAL: begin
            cmd.open_load  = 1'b1;
            cmd.set_action = status.goal;
            cmd.action     = dfmw_pkg::ACT_DONE;
            cmd.dir_zero   = !status.goal;
         end
         dfmw_pkg::ST_DIR: begin
            priority if (status.dir_open) cmd.vis_rd = 1'b1;
            else if (status.dir_last) begin
               cmd.pop        = 1'b1;
               cmd.set_action = status.count_one;
               cmd.action     = dfmw_pkg::ACT_DONE;
            end
            else cmd.dir_inc = 1'b1;
         end
         dfmw_pkg::ST_CHECK: begin
            priority if (status.visit_ok) begin
               cmd.push       = 1'b1;
               cmd.set_action = 1'b1;
               cmd.action     = dfmw_pkg::ACT_ADVANCE;
            end
            else if (status.dir_last) begin
               cmd.pop        = 1'b1;
               cmd.set_action = status.count_one;
               cmd.action     = dfmw_pkg::ACT_DONE;
            end
            else cmd.dir_inc = 1'b1;
         end
         dfmw_pkg::ST_POP_WAIT: begin
            cmd.pop_load   = 1'b1;
            cmd.set_action = 1'b1;
            cmd.action     = dfmw_pkg::ACT_BACK;
         end
         dfmw_pkg::ST_FINISH: cmd.load_rsp = out_free;
      endcase
   end

   always_comb begin
      priority if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfmw_pkg::ST_BOOT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/dfmw_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfmw_dp: maze walker datapath
// Wall store, row-wide visited map, path stack, position, grid registers and
// the output register.
// ----------------------------------------------------------------------------
module dfmw_dp #(
   parameter int unsigned MAX_WIDTH  = 64,
   parameter int unsigned MAX_HEIGHT = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dfmw_pkg::cmd_type                   cmd,
   output dfmw_pkg::status_type                status,
   input  logic [dfmw_pkg::POS_W-1:0]          req_cell_x,
   input  logic [dfmw_pkg::POS_W-1:0]          req_cell_y,
   input  logic [dfmw_pkg::MASK_W-1:0]         req_wall_mask,
   input  logic                                csr_valid,
   input  logic [dfmw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dfmw_pkg::CFG_W-1:0]          csr_wdata,
   output logic [dfmw_pkg::POS_W-1:0]          rsp_pos_x,
   output logic [dfmw_pkg::POS_W-1:0]          rsp_pos_y,
   output logic [dfmw_pkg::MASK_W-1:0]         rsp_open_neighbours,
   output logic [1:0]                          rsp_action
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int SI    = $clog2(CELLS);
   localparam int SW    = $clog2(CELLS + 1);

   logic [dfmw_pkg::MASK_W-1:0] wall_mem  [2**AW];
   logic [MAX_WIDTH-1:0]        vis_mem   [MAX_HEIGHT];
   logic [AW-1:0]               stack_mem [CELLS];

   logic [dfmw_pkg::MASK_W-1:0] wall_rd_ff;
   logic [MAX_WIDTH-1:0]        row_rd_ff;
   logic [AW-1:0]               stack_rd_ff;

   logic [dfmw_pkg::CFG_W-1:0]  grid_w_ff, grid_w_in, grid_h_ff, grid_h_in;
   logic [XW-1:0]               cx_ff, cx_in, nx_ff, nx_in;
   logic [YW-1:0]               cy_ff, cy_in, ny_ff, ny_in;
   logic [SW-1:0]               count_ff, count_in;
   logic [dfmw_pkg::MASK_W-1:0] open_ff, open_in, open_c;
   dfmw_pkg::action_type        action_ff, action_in;
   logic [2:0]                  dir_ff, dir_in;
   logic [YW-1:0]               clr_row_ff, clr_row_in;
   logic [dfmw_pkg::POS_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [dfmw_pkg::MASK_W-1:0] rsp_open_ff, rsp_open_in;
   dfmw_pkg::action_type        rsp_action_ff, rsp_action_in;

   logic [XW:0]   w_eff;
   logic [YW:0]   h_eff;
   logic [XW-1:0] cand_x;
   logic [YW-1:0] cand_y;
   logic          load_in_range;
   logic          clear_last;

   always_comb begin
      priority if (grid_w_ff == '0) w_eff = (XW+1)'(1);
      else if (32'(grid_w_ff) > MAX_WIDTH) w_eff = (XW+1)'(MAX_WIDTH);
      else w_eff = (XW+1)'(grid_w_ff);
      priority if (grid_h_ff == '0) h_eff = (YW+1)'(1);
      else if (32'(grid_h_ff) > MAX_HEIGHT) h_eff = (YW+1)'(MAX_HEIGHT);
      else h_eff = (YW+1)'(grid_h_ff);
   end

   // Underflow past column or row zero wraps above any extent in use.
   always_comb begin
      logic [XW:0] nx_e;
      logic [YW:0] ny_e;
      open_c = '0;
      for (int i = 0; i < 8; i++) begin
         nx_e = {1'b0, cx_ff} + (XW+1)'($signed(dfmw_pkg::DIR_DX[i]));
         ny_e = {1'b0, cy_ff} + (YW+1)'($signed(dfmw_pkg::DIR_DY[i]));
         if (nx_e < w_eff && ny_e < h_eff &&
             (wall_rd_ff & dfmw_pkg::DIR_BIT[i]) == '0) begin
            open_c = open_c | dfmw_pkg::DIR_BIT[i];
         end
      end
   end

   assign cand_x = XW'({1'b0, cx_ff} + (XW+1)'($signed(dfmw_pkg::DIR_DX[dir_ff])));
   assign cand_y = YW'({1'b0, cy_ff} + (YW+1)'($signed(dfmw_pkg::DIR_DY[dir_ff])));

   assign load_in_range = (32'(req_cell_x) < MAX_WIDTH) && (32'(req_cell_y) < MAX_HEIGHT);
   assign clear_last    = (clr_row_ff == YW'(MAX_HEIGHT - 1));

   assign status.count_zero = (count_ff == '0);
   assign status.count_one  = (count_ff == SW'(1));
   assign status.goal       = ({1'b0, cx_ff} == w_eff - (XW+1)'(1)) &&
                              ({1'b0, cy_ff} == h_eff - (YW+1)'(1));
   assign status.dir_open   = |(open_ff & dfmw_pkg::DIR_BIT[dir_ff]);
   assign status.dir_last   = (dir_ff == dfmw_pkg::DIR_LAST);
   assign status.visit_ok   = !row_rd_ff[nx_ff] && (count_ff < SW'(CELLS));
   assign status.clear_last = clear_last;

   always_comb begin
      grid_w_in = grid_w_ff;
      grid_h_in = grid_h_ff;
      if (csr_valid) begin
         unique case (csr_index)
            dfmw_pkg::CSR_GRID_WIDTH:  grid_w_in = csr_wdata;
            dfmw_pkg::CSR_GRID_HEIGHT: grid_h_in = csr_wdata;
         endcase
      end
   end

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      count_in = count_ff;
      priority if (cmd.restart) begin
         cx_in    = '0;
         cy_in    = '0;
         count_in = SW'(1);
      end else if (cmd.push) begin
         cx_in    = nx_ff;
         cy_in    = ny_ff;
         count_in = count_ff + SW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - SW'(1);
      end else if (cmd.pop_load) begin
         cx_in = stack_rd_ff[XW-1:0];
         cy_in = stack_rd_ff[AW-1:XW];
      end
   end

   always_comb begin
      priority if (cmd.open_zero) open_in = '0;
      else if (cmd.open_load) open_in = open_c;
      else open_in = open_ff;
      action_in = cmd.set_action ? cmd.action : action_ff;
      priority if (cmd.dir_zero) dir_in = '0;
      else if (cmd.dir_inc) dir_in = dir_ff + 3'd1;
      else dir_in = dir_ff;
      nx_in = cmd.vis_rd ? cand_x : nx_ff;
      ny_in = cmd.vis_rd ? cand_y : ny_ff;
      priority if (!cmd.clear_step) clr_row_in = clr_row_ff;
      else if (clear_last) clr_row_in = '0;
      else clr_row_in = clr_row_ff + YW'(1);
   end

   always_comb begin
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_open_in   = rsp_open_ff;
      rsp_action_in = rsp_action_ff;
      if (cmd.load_rsp) begin
         rsp_x_in      = dfmw_pkg::POS_W'(cx_ff);
         rsp_y_in      = dfmw_pkg::POS_W'(cy_ff);
         rsp_open_in   = open_ff;
         rsp_action_in = action_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_w_ff  <= dfmw_pkg::CFG_RESET;
         grid_h_ff  <= dfmw_pkg::CFG_RESET;
         cx_ff      <= '0;
         cy_ff      <= '0;
         count_ff   <= SW'(1);
         dir_ff     <= '0;
         clr_row_ff <= '0;
      end else begin
         grid_w_ff  <= grid_w_in;
         grid_h_ff  <= grid_h_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         count_ff   <= count_in;
         dir_ff     <= dir_in;
         clr_row_ff <= clr_row_in;
      end
   end

   always_ff @(posedge clock) begin
      open_ff       <= open_in;
      action_ff     <= action_in;
      nx_ff         <= nx_in;
      ny_ff         <= ny_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_action_ff <= rsp_action_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.wall_wr && load_in_range) begin
         wall_mem[{YW'(req_cell_y), XW'(req_cell_x)}] <= req_wall_mask;
      end
      if (cmd.wall_rd) begin
         wall_rd_ff <= wall_mem[{cy_ff, cx_ff}];
      end
   end

   // Row zero comes back with the start cell marked.
   always_ff @(posedge clock) begin
      priority if (cmd.clear_step) begin
         vis_mem[clr_row_ff] <= (clr_row_ff == '0) ? MAX_WIDTH'(1) : '0;
      end else if (cmd.push) begin
         vis_mem[ny_ff] <= row_rd_ff | (MAX_WIDTH'(1) << nx_ff);
      end
      if (cmd.vis_rd) begin
         row_rd_ff <= vis_mem[cand_y];
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.clear_step) begin
         stack_mem[0] <= '0;
      end else if (cmd.push) begin
         stack_mem[SI'(count_ff)] <= {ny_ff, nx_ff};
      end
      if (cmd.pop) begin
         stack_rd_ff <= stack_mem[SI'(count_ff - SW'(2))];
      end
   end

   assign rsp_pos_x           = rsp_x_ff;
   assign rsp_pos_y           = rsp_y_ff;
   assign rsp_open_neighbours = rsp_open_ff;
   assign rsp_action          = rsp_action_ff;

endmodule

// ===== rtl/core/grid_depth_first_maze_walker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_depth_first_maze_walker: depth-first search over an 8-connected grid
// Loads cell walls, restarts the search and takes one search step per
// transaction, returning one result transaction each time.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per item; req_kind selects wall load, step or
//            restart. Accepted when req_valid and req_ready are high.
//   rsp_*  : one result per request, held in an output register until taken.
//   csr_*  : grid width (index 0) and height (index 1); always ready, write
//            only while no request is outstanding.
// Order of work: a wall load or unused kind goes straight to the result;
//   a restart first sweeps the visited map one row per cycle. A step on an
//   empty stack returns without reading the wall, and one at the goal after
//   the wall read; otherwise it tries the directions in order, reading the
//   visited row of each open one, and reads the stack on backtrack.
// One request is in the datapath at a time; the next can be taken once the
// result is in the output register, even while the receiver stalls it. A
// second result waits in the controller until the first is taken.
// Reset: the visited map is swept row by row with req_ready low;
//   grid registers come up at 64, position (0,0), stack holding (0,0).
// ----------------------------------------------------------------------------
module grid_depth_first_maze_walker #(
   parameter int unsigned MAX_WIDTH  = 64,
   parameter int unsigned MAX_HEIGHT = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dfmw_pkg::KIND_W-1:0]       req_kind,
   input  logic [dfmw_pkg::POS_W-1:0]        req_cell_x,
   input  logic [dfmw_pkg::POS_W-1:0]        req_cell_y,
   input  logic [dfmw_pkg::MASK_W-1:0]       req_wall_mask,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dfmw_pkg::POS_W-1:0]        rsp_pos_x,
   output logic [dfmw_pkg::POS_W-1:0]        rsp_pos_y,
   output logic [dfmw_pkg::MASK_W-1:0]       rsp_open_neighbours,
   output logic [1:0]                        rsp_action,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dfmw_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dfmw_pkg::CFG_W-1:0]        csr_wdata
);

   dfmw_pkg::cmd_type    cmd;
   dfmw_pkg::status_type status;

   assign csr_ready = 1'b1;

   dfmw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dfmw_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_cell_x          (req_cell_x),
      .req_cell_y          (req_cell_y),
      .req_wall_mask       (req_wall_mask),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_pos_x           (rsp_pos_x),
      .rsp_pos_y           (rsp_pos_y),
      .rsp_open_neighbours (rsp_open_neighbours),
      .rsp_action          (rsp_action)
   );

endmodule

// ===== rtl/core/dfmw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfmw_checker: port-level checks for the maze walker
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module dfmw_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [dfmw_pkg::POS_W-1:0]        rsp_pos_x,
   input  logic [dfmw_pkg::POS_W-1:0]        rsp_pos_y,
   input  logic [dfmw_pkg::MASK_W-1:0]       rsp_open_neighbours,
   input  logic [1:0]                        rsp_action
);

   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_action) &&
      $stable(rsp_pos_x) && $stable(rsp_pos_y) && $stable(rsp_open_neighbours))
      else $error("result changed while stalled");

   ack_open_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == dfmw_pkg::ACT_ACK |-> rsp_open_neighbours == '0)
      else $error("acknowledge carries open neighbors");

   advance_open_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == dfmw_pkg::ACT_ADVANCE |-> rsp_open_neighbours != '0)
      else $error("advance without an open neighbor");

   one_at_a_time_a: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction taken while one is in work");

endmodule

bind grid_depth_first_maze_walker dfmw_checker u_dfmw_checker (.*);
